/* src/tlik_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared widths, constants, cell payload types and the CORDIC angle table
// for the two-link inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package tlik_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned LenW   = 15;
  localparam int unsigned AngW   = 18;

  localparam int unsigned NumW   = 33;
  localparam int unsigned DenW   = 31;
  localparam int unsigned RadW   = 62;
  localparam int unsigned RootW  = 31;
  localparam int unsigned RemW   = 33;

  localparam int unsigned LaneW  = 52;
  localparam int unsigned MagW   = 49;
  localparam int unsigned ZW     = 24;

  // Vectors are scaled up until the larger magnitude reaches 2^NormBits.
  localparam int unsigned NormBits  = 40;
  localparam int unsigned NormSteps = 6;

  localparam logic [LenW-1:0]      LenReset  = 15'd4096;
  localparam logic signed [ZW-1:0] AngPi     = 24'sd3294199;
  localparam logic signed [ZW-1:0] AngHalfPi = 24'sd1647099;

  typedef enum logic {
    CfgFirstLen  = 1'b0,
    CfgSecondLen = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic                    spec;
    logic signed [ZW-1:0]    z;
    logic signed [LaneW-1:0] x;
    logic signed [LaneW-1:0] y;
    logic [MagW-1:0]         mag;
  } lane_t;

  // atan(2^-i) in units of 2^-20 rad.
  function automatic logic signed [ZW-1:0] atan_lut(input int unsigned idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:       val = 24'sd823550;
      1:       val = 24'sd486170;
      2:       val = 24'sd256879;
      3:       val = 24'sd130396;
      4:       val = 24'sd65451;
      5:       val = 24'sd32757;
      6:       val = 24'sd16383;
      7:       val = 24'sd8192;
      8:       val = 24'sd4096;
      9:       val = 24'sd2048;
      10:      val = 24'sd1024;
      11:      val = 24'sd512;
      12:      val = 24'sd256;
      13:      val = 24'sd128;
      14:      val = 24'sd64;
      15:      val = 24'sd32;
      16:      val = 24'sd16;
      17:      val = 24'sd8;
      18:      val = 24'sd4;
      19:      val = 24'sd2;
      20:      val = 24'sd1;
      default: val = 24'sd0;
    endcase
    return val;
  endfunction

endpackage

/* src/tlik_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_sqrt_cell
// One digit of a restoring integer square root: takes the next two radicand
// bits and decides one root bit, then registers the partial result.
// ----------------------------------------------------------------------------
module tlik_sqrt_cell
  import tlik_pkg::*;
(
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t cell_i,
  output sqrt_t cell_o
);

  logic [RemW+1:0] rem_sh;
  logic [RemW+1:0] trial;
  logic [RemW+1:0] diff;
  logic            ge;
  sqrt_t           cell_d, cell_q;

  always_comb begin
    rem_sh      = {cell_i.rem, cell_i.rad[RadW-1 -: 2]};
    trial       = {2'b00, cell_i.root, 2'b01};
    diff        = rem_sh - trial;
    ge          = (rem_sh >= trial);
    cell_d.rad  = {cell_i.rad[RadW-3:0], 2'b00};
    cell_d.rem  = ge ? diff[RemW-1:0] : rem_sh[RemW-1:0];
    cell_d.root = {cell_i.root[RootW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* src/tlik_norm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_norm_cell
// One step of the vector normalisation: doubles the vector SHIFT times when
// that keeps its larger magnitude below 2^(NormBits+1).
// ----------------------------------------------------------------------------
module tlik_norm_cell
  import tlik_pkg::*;
#(
  parameter int unsigned SHIFT = 1
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  lane_t cell_i,
  output lane_t cell_o
);

  localparam int unsigned TopBit = NormBits + 1 - SHIFT;

  logic  room;
  lane_t cell_d, cell_q;

  always_comb begin
    room   = (cell_i.mag[MagW-1:TopBit] == '0);
    cell_d = cell_i;
    if (room) begin
      cell_d.x   = cell_i.x <<< SHIFT;
      cell_d.y   = cell_i.y <<< SHIFT;
      cell_d.mag = cell_i.mag << SHIFT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* src/tlik_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_cordic_cell
// One vectoring-mode CORDIC micro-rotation, registered. Lanes whose angle
// was settled up front keep their angle untouched.
// ----------------------------------------------------------------------------
module tlik_cordic_cell
  import tlik_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  lane_t cell_i,
  output lane_t cell_o
);

  localparam logic signed [ZW-1:0] Step = atan_lut(STAGE);

  logic                    up;
  logic signed [LaneW-1:0] xs, ys;
  lane_t                   cell_d, cell_q;

  always_comb begin
    up     = !cell_i.y[LaneW-1];
    xs     = cell_i.x >>> STAGE;
    ys     = cell_i.y >>> STAGE;
    cell_d = cell_i;
    if (up) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      if (!cell_i.spec) begin
        cell_d.z = cell_i.z + Step;
      end
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      if (!cell_i.spec) begin
        cell_d.z = cell_i.z - Step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* src/two_link_inverse_kinematics.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics
// Planar two-link arm inverse kinematics: elbow-up and elbow-down joint
// angles for a target point, built from a square-root cell chain and three
// CORDIC cell chains.
// ----------------------------------------------------------------------------
// The block takes one target per clock and returns one result per clock,
// in order, whenever the output is not stalled. An input transfer passes
// through stages A to D for squaring and reach test, a row of 31
// square-root cells (one root bit each), stages E and F forming the
// shoulder terms, a set-up register, six normalisation cells, a quadrant
// register and CORDIC_STAGES rotation cells, then the output register. A stall
// on the output freezes the whole row of cells; the output register holds a
// finished result while earlier items stay in flight. Link lengths may be
// written only while no item is in flight.
module two_link_inverse_kinematics
  import tlik_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [LenW-1:0]         cfg_wdata_i,

  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [CoordW-1:0] target_x_i,
  input  logic signed [CoordW-1:0] target_y_i,

  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    reachable_o,
  output logic signed [AngW-1:0]  shoulder_angle_up_o,
  output logic signed [AngW-1:0]  elbow_angle_up_o,
  output logic signed [AngW-1:0]  shoulder_angle_down_o,
  output logic signed [AngW-1:0]  elbow_angle_down_o
);

  localparam int unsigned LateDepth = 2 + NormSteps + CORDIC_STAGES;
  localparam int unsigned Depth     = 4 + RootW + 2 + LateDepth;
  localparam int unsigned Lanes     = 3;

  typedef struct packed {
    logic                     reach;
    logic signed [NumW-1:0]   num;
    logic [DenW-1:0]          den;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } side_t;

  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // Configuration registers and the link-length products.
  logic [LenW-1:0]     l1_q, l2_q;
  logic [2*LenW-1:0]   l1sq_q, l2sq_q, l12_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= LenReset;
      l2_q <= LenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgFirstLen:  l1_q <= cfg_wdata_i;
        CfgSecondLen: l2_q <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    l1sq_q <= l1_q * l1_q;
    l2sq_q <= l2_q * l2_q;
    l12_q  <= l1_q * l2_q;
  end

  // Valid bits for every stage.
  logic [Depth-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // Stage A: squares of the target.
  logic signed [CoordW-1:0] xa_q, ya_q;
  logic [2*CoordW-1:0]      xx_q, yy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_q <= target_x_i;
      ya_q <= target_y_i;
      xx_q <= target_x_i * target_x_i;
      yy_q <= target_y_i * target_y_i;
    end
  end

  // Stage B: numerator and denominator of the elbow cosine.
  logic signed [CoordW-1:0] xb_q, yb_q;
  logic signed [NumW-1:0]   numb_q;
  logic [DenW-1:0]          denb_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      xb_q   <= xa_q;
      yb_q   <= ya_q;
      numb_q <= $signed({1'b0, xx_q} + {1'b0, yy_q} - {3'b000, l1sq_q} - {3'b000, l2sq_q});
      denb_q <= {l12_q, 1'b0};
    end
  end

  // Stage C: reach test and the two squares under the root.
  logic [NumW-2:0]        anum;
  logic [2*(NumW-1)-1:0]  numsq_q;
  logic [2*DenW-1:0]      densq_q;
  side_t                  sidec_q;
  assign anum = numb_q[NumW-1] ? (NumW-1)'(-numb_q) : (NumW-1)'(numb_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      numsq_q       <= anum * anum;
      densq_q       <= denb_q * denb_q;
      sidec_q.reach <= (anum <= {1'b0, denb_q});
      sidec_q.num   <= numb_q;
      sidec_q.den   <= denb_q;
      sidec_q.x     <= xb_q;
      sidec_q.y     <= yb_q;
    end
  end

  // Stage D: radicand den^2 - num^2.
  logic [2*(NumW-1)-1:0] rad_full;
  logic [RadW-1:0]       rad_q;
  side_t                 sided_q;
  assign rad_full = {2'b00, densq_q} - numsq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q   <= rad_full[RadW-1:0];
      sided_q <= sidec_q;
    end
  end

  // Square-root cell row, with the side data travelling alongside.
  sqrt_t sq [RootW+1];
  side_t sdl_q [RootW];

  assign sq[0] = '{rad: rad_q, rem: '0, root: '0};

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    tlik_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (sq[k]),
      .cell_o (sq[k+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        sdl_q[k] <= (k == 0) ? sided_q : sdl_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  side_t sqs;
  assign sqs = sdl_q[RootW-1];

  // Stage E: products for the shoulder correction angle.
  logic [RootW-1:0]          se_q;
  logic [LenW+RootW-1:0]     pye_q, pae_q;
  logic signed [MagW-1:0]    pbe_q;
  logic signed [NumW-1:0]    nume_q;
  logic signed [CoordW-1:0]  xe_q, ye_q;
  logic                      reache_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      se_q     <= sq[RootW].root;
      pye_q    <= l2_q * sq[RootW].root;
      pae_q    <= l1_q * sqs.den;
      pbe_q    <= $signed({1'b0, l2_q}) * sqs.num;
      nume_q   <= sqs.num;
      xe_q     <= sqs.x;
      ye_q     <= sqs.y;
      reache_q <= sqs.reach;
    end
  end

  // Stage F: cosine term of the shoulder correction.
  logic [RootW-1:0]          sf_q;
  logic [LenW+RootW-1:0]     pyf_q;
  logic signed [MagW-1:0]    pxf_q;
  logic signed [NumW-1:0]    numf_q;
  logic signed [CoordW-1:0]  xf_q, yf_q;
  logic                      reachf_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sf_q     <= se_q;
      pyf_q    <= pye_q;
      pxf_q    <= $signed({3'b000, pae_q}) + pbe_q;
      numf_q   <= nume_q;
      xf_q     <= xe_q;
      yf_q     <= ye_q;
      reachf_q <= reache_q;
    end
  end

  // Lane 0: elbow angle, lane 1: base angle, lane 2: shoulder correction.
  logic signed [MagW-1:0] gy [Lanes];
  logic signed [MagW-1:0] gx [Lanes];

  always_comb begin
    gy[0] = $signed({{(MagW-RootW){1'b0}}, sf_q});
    gx[0] = MagW'(numf_q);
    gy[1] = MagW'(yf_q);
    gx[1] = MagW'(xf_q);
    gy[2] = $signed({{(MagW-LenW-RootW){1'b0}}, pyf_q});
    gx[2] = pxf_q;
  end

  lane_t nm [Lanes][NormSteps+1];
  lane_t cd [Lanes][CORDIC_STAGES+1];

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    logic [MagW-1:0] ax, ay;
    lane_t           prep, prep_q, quad, quad_q;

    // Set-up: angles that need no rotation, and the larger magnitude.
    always_comb begin
      ax        = gx[l][MagW-1] ? MagW'(-gx[l]) : MagW'(gx[l]);
      ay        = gy[l][MagW-1] ? MagW'(-gy[l]) : MagW'(gy[l]);
      prep.x    = LaneW'(gx[l]);
      prep.y    = LaneW'(gy[l]);
      prep.mag  = (ax > ay) ? ax : ay;
      prep.spec = (gy[l] == '0) || (gx[l] == '0);
      if (gy[l] == '0) begin
        prep.z = gx[l][MagW-1] ? AngPi : '0;
      end else if (gx[l] == '0) begin
        prep.z = gy[l][MagW-1] ? -AngHalfPi : AngHalfPi;
      end else begin
        prep.z = '0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        prep_q <= prep;
      end
    end

    assign nm[l][0] = prep_q;

    for (genvar k = 0; k < NormSteps; k++) begin : g_norm
      tlik_norm_cell #(
        .SHIFT (1 << (NormSteps - 1 - k))
      ) u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .cell_i (nm[l][k]),
        .cell_o (nm[l][k+1])
      );
    end

    // Fold the left half-plane onto the right by a quarter turn.
    always_comb begin
      quad = nm[l][NormSteps];
      if (!quad.spec && nm[l][NormSteps].x[LaneW-1]) begin
        if (!nm[l][NormSteps].y[LaneW-1]) begin
          quad.x = nm[l][NormSteps].y;
          quad.y = -nm[l][NormSteps].x;
          quad.z = AngHalfPi;
        end else begin
          quad.x = -nm[l][NormSteps].y;
          quad.y = nm[l][NormSteps].x;
          quad.z = -AngHalfPi;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        quad_q <= quad;
      end
    end

    assign cd[l][0] = quad_q;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
      tlik_cordic_cell #(
        .STAGE (k)
      ) u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .cell_i (cd[l][k]),
        .cell_o (cd[l][k+1])
      );
    end
  end

  // Reach flag runs alongside the lanes.
  logic [LateDepth-1:0] rl_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      rl_q <= {rl_q[LateDepth-2:0], reachf_q};
    end
  end

  // Final combination and rounding to Q3.14.
  logic signed [ZW-1:0] ze, zb, zp, er;
  logic signed [ZW:0]   su, sd;
  logic                 reach_fin;

  always_comb begin
    ze        = cd[0][CORDIC_STAGES].z;
    zb        = cd[1][CORDIC_STAGES].z;
    zp        = cd[2][CORDIC_STAGES].z;
    er        = ze + ZW'(32);
    su        = (ZW+1)'(zb) - (ZW+1)'(zp) + (ZW+1)'(32);
    sd        = (ZW+1)'(zb) + (ZW+1)'(zp) + (ZW+1)'(32);
    reach_fin = rl_q[LateDepth-1];
  end

  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      reachable_o           <= reach_fin;
      shoulder_angle_up_o   <= reach_fin ? su[AngW+5:6] : '0;
      elbow_angle_up_o      <= reach_fin ? er[AngW+5:6] : '0;
      shoulder_angle_down_o <= reach_fin ? sd[AngW+5:6] : '0;
      elbow_angle_down_o    <= reach_fin ? -er[AngW+5:6] : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  // An unreachable target carries no angles.
  a_unreach_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reachable_o |-> shoulder_angle_up_o == '0 &&
      elbow_angle_up_o == '0 && shoulder_angle_down_o == '0 &&
      elbow_angle_down_o == '0)
    else $error("unreachable result carries nonzero angles");

  // The two elbow solutions are mirror images.
  a_elbow_mirror : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> elbow_angle_down_o == AngW'(-elbow_angle_up_o))
    else $error("elbow-down angle is not the negated elbow-up angle");

  // The pipeline only moves when the output register is free or taken.
  a_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(vld_q))
    else $error("pipeline advanced under output stall");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-link inverse kinematics testbench
// Drives target points through the pipeline under several link-length
// settings. Each accepted target is predicted with a bit-exact fixed-point
// model (integer square root and CORDIC atan2). Every returned solution is
// then compared field by field, with random idle and stall bursts on both
// channels.
// ----------------------------------------------------------------------------
module testbench;
  import tlik_pkg::*;

  localparam int unsigned Stages    = 16;
  localparam int unsigned Latency   = 46 + Stages;
  localparam int unsigned CycleCap  = 400000;
  localparam longint      AngPiQ20  = 64'sd3294199;
  localparam longint      AngHpiQ20 = 64'sd1647099;
  localparam longint      NormFloor = 64'sd1 << 40;

  typedef struct {
    logic                   reach;
    logic signed [AngW-1:0] shoulder_up;
    logic signed [AngW-1:0] elbow_up;
    logic signed [AngW-1:0] shoulder_down;
    logic signed [AngW-1:0] elbow_down;
  } ik_solution_t;

  class ik_scoreboard;
    logic [LenW-1:0] len_first;
    logic [LenW-1:0] len_second;
    ik_solution_t    solutions[$];
    int              errors;
    int              checked;
    int              reach_count;

    function new();
      len_first   = LenReset;
      len_second  = LenReset;
      errors      = 0;
      checked     = 0;
      reach_count = 0;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Vectoring CORDIC; the result is in units of 2^-20 rad.
    function automatic longint vector_angle(longint y, longint x);
      longint z, t, m, nx, ny;
      longint arctan[24];
      arctan = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                 4096, 2048, 1024, 512, 256, 128, 64, 32,
                 16, 8, 4, 2, 1, 0, 0, 0};
      z = 0;
      if (y == 0) return (x < 0) ? AngPiQ20 : 0;
      if (x == 0) return (y > 0) ? AngHpiQ20 : -AngHpiQ20;
      m = (x < 0) ? -x : x;
      t = (y < 0) ? -y : y;
      if (t > m) m = t;
      while (m < NormFloor) begin
        x = x * 2;
        y = y * 2;
        m = m * 2;
      end
      if (x < 0) begin
        if (y > 0) begin
          t = x; x = y; y = -t; z = AngHpiQ20;
        end else begin
          t = x; x = -y; y = t; z = -AngHpiQ20;
        end
      end
      for (int i = 0; i < Stages && i < 24; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z  = z + arctan[i];
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z  = z - arctan[i];
        end
        x = nx;
        y = ny;
      end
      return z;
    endfunction

    function automatic longint round_q14(longint a);
      return (a + 32) >>> 6;
    endfunction

    function void set_length(cfg_reg_e idx, logic [LenW-1:0] val);
      if (idx == CfgFirstLen) len_first = val;
      else len_second = val;
    endfunction

    function void note_target(logic signed [CoordW-1:0] tx,
                              logic signed [CoordW-1:0] ty);
      ik_solution_t sol;
      longint x, y, l1, l2, num, den, anum, s, elbow, base, phi;
      x  = tx;
      y  = ty;
      l1 = len_first;
      l2 = len_second;
      num  = x * x + y * y - l1 * l1 - l2 * l2;
      den  = 2 * l1 * l2;
      anum = (num < 0) ? -num : num;
      sol  = '{1'b0, '0, '0, '0, '0};
      if (anum <= den) begin
        s     = int_sqrt(longint'(den * den) - longint'(num * num));
        elbow = round_q14(vector_angle(s, num));
        base  = vector_angle(y, x);
        phi   = vector_angle(l2 * s, l1 * den + l2 * num);
        sol.reach         = 1'b1;
        sol.shoulder_up   = round_q14(base - phi);
        sol.elbow_up      = elbow;
        sol.shoulder_down = round_q14(base + phi);
        sol.elbow_down    = -elbow;
        reach_count++;
      end
      solutions.push_back(sol);
    endfunction

    function void check_result(ik_solution_t got);
      ik_solution_t exp_sol;
      checked++;
      if (solutions.size() == 0) begin
        $error("Result transfer with no target outstanding");
        errors++;
        return;
      end
      exp_sol = solutions.pop_front();
      if (got.reach !== exp_sol.reach) begin
        $error("reachable: expected %0d, got %0d", exp_sol.reach, got.reach);
        errors++;
      end
      if (got.shoulder_up !== exp_sol.shoulder_up) begin
        $error("shoulder_angle_up: expected %0d, got %0d",
               exp_sol.shoulder_up, got.shoulder_up);
        errors++;
      end
      if (got.elbow_up !== exp_sol.elbow_up) begin
        $error("elbow_angle_up: expected %0d, got %0d",
               exp_sol.elbow_up, got.elbow_up);
        errors++;
      end
      if (got.shoulder_down !== exp_sol.shoulder_down) begin
        $error("shoulder_angle_down: expected %0d, got %0d",
               exp_sol.shoulder_down, got.shoulder_down);
        errors++;
      end
      if (got.elbow_down !== exp_sol.elbow_down) begin
        $error("elbow_angle_down: expected %0d, got %0d",
               exp_sol.elbow_down, got.elbow_down);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic                     cfg_idx_i;
  logic [LenW-1:0]          cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [CoordW-1:0] target_x_i;
  logic signed [CoordW-1:0] target_y_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     reachable_o;
  logic signed [AngW-1:0]   shoulder_angle_up_o;
  logic signed [AngW-1:0]   elbow_angle_up_o;
  logic signed [AngW-1:0]   shoulder_angle_down_o;
  logic signed [AngW-1:0]   elbow_angle_down_o;

  ik_scoreboard sb;
  bit           calm;
  int           stall_left;
  int           cycles;
  int           sent;

  two_link_inverse_kinematics #(.CORDIC_STAGES(Stages)) uut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("Timed out after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stalls in short random bursts.
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Inputs change only at rising edges, so the falling edge sees what the
  // next rising edge will transfer.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{reachable_o, shoulder_angle_up_o, elbow_angle_up_o,
                        shoulder_angle_down_o, elbow_angle_down_o});
    end
  end

  task automatic send_target(logic signed [CoordW-1:0] x,
                             logic signed [CoordW-1:0] y);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_x_i <= x;
    target_y_i <= y;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_target(x, y);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.solutions.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_length(cfg_reg_e idx, logic [LenW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_length(idx, val);
  endtask

  // Mostly points around the reachable annulus, some anywhere at all.
  function automatic logic signed [CoordW-1:0] pick_coord(int reach);
    int v;
    if ($urandom_range(0, 3) == 0) return CoordW'($urandom);
    if (reach > 32767) reach = 32767;
    v = int'($urandom_range(0, 2 * reach)) - reach;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return CoordW'(v);
  endfunction

  task automatic random_targets(int n);
    int reach;
    reach = int'(sb.len_first) + int'(sb.len_second);
    repeat (n) send_target(pick_coord(reach), pick_coord(reach));
  endtask

  initial begin
    sb          = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgFirstLen;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    target_x_i  = '0;
    target_y_i  = '0;
    calm        = 1'b0;
    stall_left  = 0;
    cycles      = 0;
    sent        = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Reset lengths of 1.0: folded arm, full stretch, axes, quadrants,
    // the reach boundary on the diagonal and far corners.
    send_target(0, 0);
    send_target(8192, 0);
    send_target(0, 8192);
    send_target(-8192, 0);
    send_target(0, -8192);
    send_target(0, 4096);
    send_target(-4096, 0);
    send_target(4096, 4096);
    send_target(-4096, 4096);
    send_target(-4096, -4096);
    send_target(4096, -4096);
    send_target(5792, 5792);
    send_target(5793, 5793);
    send_target(1, 0);
    send_target(0, -1);
    send_target(32767, 32767);
    send_target(-32768, -32768);
    send_target(32767, -32768);
    send_target(-32768, 32767);
    random_targets(100);
    drain();

    write_length(CfgFirstLen, 15'd1);
    write_length(CfgSecondLen, 15'd1);
    send_target(2, 0);
    send_target(0, 0);
    send_target(1, 1);
    send_target(0, -2);
    send_target(-3, 0);
    random_targets(90);
    drain();

    write_length(CfgFirstLen, 15'd32767);
    write_length(CfgSecondLen, 15'd1);
    send_target(32767, 0);
    send_target(-32768, 0);
    send_target(32766, 0);
    send_target(0, 32767);
    random_targets(90);
    drain();

    write_length(CfgSecondLen, 15'd32767);
    send_target(0, 0);
    send_target(-32768, -32768);
    random_targets(90);
    drain();

    write_length(CfgFirstLen, LenW'($urandom_range(1, 32767)));
    write_length(CfgSecondLen, LenW'($urandom_range(1, 32767)));
    random_targets(90);
    drain();

    // Last stretch runs back to back with no idling on either side.
    write_length(CfgFirstLen, LenW'($urandom_range(1000, 16000)));
    write_length(CfgSecondLen, LenW'($urandom_range(1000, 16000)));
    calm = 1'b1;
    random_targets(90);
    in_valid_i <= 1'b0;

    @(negedge clk_i);
    while (sb.solutions.size() != 0) @(negedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);

    $display("Sent %0d targets under six link settings; %0d results checked, %0d reachable.",
             sent, sb.checked, sb.reach_count);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
